// ===== hw/rtl/hpp_pkg.sv =====
// shared types and constants for the homogeneous point projection block
package hpp_pkg;

    localparam int COORD_W     = 32;
    localparam int CFG_W       = 64;
    localparam int NUM_REGS    = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_SEL_W   = $clog2(NUM_REGS);
    localparam int COL_W       = 64;
    localparam int NUM_COLS    = 4;
    localparam int NUM_LANES   = 3;
    localparam int DIV_STEPS   = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [COORD_W-1:0] x_in;
        logic signed [COORD_W-1:0] y_in;
        logic signed [COORD_W-1:0] z_in;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_out;
        logic signed [COORD_W-1:0] y_out;
        logic signed [COORD_W-1:0] z_out;
        logic                      w_was_zero;
        logic                      overflowed;
    } result_t;

    typedef logic [CFG_W-1:0] cfg_reg_t;
    typedef cfg_reg_t [NUM_REGS-1:0] matrix_t;

    // column values c0, c1, c2 and w, two's complement
    typedef logic [NUM_COLS-1:0][COL_W-1:0] cols_t;

    localparam matrix_t CFG_RESET = {
        64'h0001_0000_0000_0000, 64'h0,
        64'h0000_0000_0001_0000, 64'h0,
        64'h0,                   64'h0001_0000_0000_0000,
        64'h0,                   64'h0000_0000_0001_0000
    };

endpackage

// ===== hw/rtl/hpp_front.sv =====
// front end: matrix products and column sums
module hpp_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  hpp_pkg::point_t point,
    input  hpp_pkg::matrix_t matrix,
    output logic            push,
    output hpp_pkg::cols_t  cols
);
    import hpp_pkg::*;

    localparam int SUM_W = 2 * COORD_W + 2;

    function automatic logic signed [COORD_W-1:0] entry(input matrix_t m, input int row,
                                                       input int col);
        cfg_reg_t r;
        r = m[CFG_SEL_W'(row * 2 + (col >> 1))];
        entry = ((col & 1) != 0) ? r[CFG_W-1:COORD_W] : r[COORD_W-1:0];
    endfunction

    logic signed [2*COORD_W-1:0] prod_reg [NUM_LANES][NUM_COLS];
    logic                        prod_valid_reg;
    cols_t                       cols_reg;
    logic                        cols_valid_reg;

    logic signed [COORD_W-1:0]   vin [NUM_LANES];

    always_comb
    begin
        vin[0] = point.x_in;
        vin[1] = point.y_in;
        vin[2] = point.z_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            cols_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= take;
            cols_valid_reg <= prod_valid_reg;
        end
    end

    // one 32x32 product per matrix entry of the top three rows
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            for (int j = 0; j < NUM_COLS; j++)
            begin
                prod_reg[i][j] <= vin[i] * entry(matrix, i, j);
            end
        end
    end

    // exact sum, floor to the output scale, then add the constant row
    always_ff @(posedge clk)
    begin
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] shifted;
        for (int j = 0; j < NUM_COLS; j++)
        begin
            sum = SUM_W'(prod_reg[0][j]) + SUM_W'(prod_reg[1][j]) + SUM_W'(prod_reg[2][j]);
            shifted = sum >>> FRAC_BITS;
            cols_reg[j] <= shifted[COL_W-1:0] + COL_W'(entry(matrix, 3, j));
        end
    end

    assign push = cols_valid_reg;
    assign cols = cols_reg;

endmodule

// ===== hw/rtl/hpp_queue.sv =====
// short first-word-fall-through queue between front and back
module hpp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hpp_pkg::cols_t din,
    output logic           full,
    output logic           valid,
    input  logic           pop,
    output hpp_pkg::cols_t dout
);
    import hpp_pkg::*;

    cols_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hw/rtl/hpp_back.sv =====
// back end: homogeneous divide, one quotient bit per stage, and saturation
module hpp_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    input  hpp_pkg::cols_t   cols,
    output logic             done,
    output hpp_pkg::result_t result
);
    import hpp_pkg::*;

    localparam int NUM_W = COL_W + FRAC_BITS;

    typedef struct packed {
        logic [COL_W-1:0]   rem;
        logic [DIV_STEPS-1:0] nlo;
        logic [DIV_STEPS-1:0] q;
    } lane_t;

    typedef struct packed {
        logic                               wz;
        logic [COL_W-1:0]                   den;
        logic [NUM_LANES-1:0]               neg;
        logic [NUM_LANES-1:0]               ovf;
        logic [NUM_LANES-1:0][COORD_W-1:0]  pass;
        logic [NUM_LANES-1:0]               pass_ov;
    } meta_t;

    lane_t                lane_reg [DIV_STEPS+1][NUM_LANES];
    meta_t                meta_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0]   valid_reg;
    result_t              result_reg;
    logic                 done_reg;

    lane_t                lane_init [NUM_LANES];
    meta_t                meta_init;

    function automatic lane_t div_step(input lane_t l, input logic [COL_W-1:0] den);
        logic [COL_W:0] t;
        logic [COL_W:0] d;
        lane_t          n;
        t = {l.rem, l.nlo[DIV_STEPS-1]};
        d = {1'b0, den};
        n.nlo = {l.nlo[DIV_STEPS-2:0], 1'b0};
        if (t >= d)
        begin
            t = t - d;
            n.q = {l.q[DIV_STEPS-2:0], 1'b1};
        end
        else
        begin
            n.q = {l.q[DIV_STEPS-2:0], 1'b0};
        end
        n.rem = t[COL_W-1:0];
        div_step = n;
    endfunction

    // setup: magnitudes, signs, range check of the quotient, undivided values
    always_comb
    begin
        logic [COL_W-1:0]       mag;
        logic [NUM_W-1:0]       num;
        logic [NUM_W-33:0]      r0;
        logic signed [COL_W-1:0] c;
        meta_init.wz  = (cols[NUM_COLS-1] == '0);
        meta_init.den = cols[NUM_COLS-1][COL_W-1] ? (COL_W'(0) - cols[NUM_COLS-1])
                                                  : cols[NUM_COLS-1];
        for (int j = 0; j < NUM_LANES; j++)
        begin
            c   = $signed(cols[j]);
            mag = c[COL_W-1] ? (COL_W'(0) - cols[j]) : cols[j];
            num = {mag, {FRAC_BITS{1'b0}}};
            r0  = num[NUM_W-1:DIV_STEPS];
            meta_init.neg[j] = c[COL_W-1] ^ cols[NUM_COLS-1][COL_W-1];
            meta_init.ovf[j] = (COL_W'(r0) >= meta_init.den);
            lane_init[j].rem = COL_W'(r0);
            lane_init[j].nlo = num[DIV_STEPS-1:0];
            lane_init[j].q   = '0;
            if (c > $signed(COL_W'(32'h7fff_ffff)))
            begin
                meta_init.pass[j]    = 32'h7fff_ffff;
                meta_init.pass_ov[j] = 1'b1;
            end
            else if (c < -$signed(COL_W'(33'h0_8000_0000)))
            begin
                meta_init.pass[j]    = 32'h8000_0000;
                meta_init.pass_ov[j] = 1'b1;
            end
            else
            begin
                meta_init.pass[j]    = c[COORD_W-1:0];
                meta_init.pass_ov[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[DIV_STEPS-1:0], valid};
            done_reg  <= valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg[0] <= meta_init;
        for (int j = 0; j < NUM_LANES; j++)
        begin
            lane_reg[0][j] <= lane_init[j];
        end
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            meta_reg[s+1] <= meta_reg[s];
            for (int j = 0; j < NUM_LANES; j++)
            begin
                lane_reg[s+1][j] <= div_step(lane_reg[s][j], meta_reg[s].den);
            end
        end
    end

    // sign and saturate
    always_ff @(posedge clk)
    begin
        logic [NUM_LANES-1:0][COORD_W-1:0] val;
        logic [NUM_LANES-1:0]              ov;
        logic [DIV_STEPS-1:0]              qv;
        meta_t                             m;
        m = meta_reg[DIV_STEPS];
        for (int j = 0; j < NUM_LANES; j++)
        begin
            qv = lane_reg[DIV_STEPS][j].q;
            if (m.wz)
            begin
                val[j] = m.pass[j];
                ov[j]  = m.pass_ov[j];
            end
            else if (m.neg[j])
            begin
                if (m.ovf[j] || (qv > 32'h8000_0000))
                begin
                    val[j] = 32'h8000_0000;
                    ov[j]  = 1'b1;
                end
                else
                begin
                    val[j] = 32'd0 - qv;
                    ov[j]  = 1'b0;
                end
            end
            else
            begin
                if (m.ovf[j] || qv[DIV_STEPS-1])
                begin
                    val[j] = 32'h7fff_ffff;
                    ov[j]  = 1'b1;
                end
                else
                begin
                    val[j] = qv;
                    ov[j]  = 1'b0;
                end
            end
        end
        result_reg.x_out      <= val[0];
        result_reg.y_out      <= val[1];
        result_reg.z_out      <= val[2];
        result_reg.w_was_zero <= m.wz;
        result_reg.overflowed <= |ov;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/homogeneous_point_projection.sv =====
// top level of the homogeneous point projection block
//
// projects one point word [x y z 1] through a 4x4 matrix and divides x, y, z
// by w; takes a new point every clock cycle while busy is low and marks each
// result word by done for one cycle; the result cannot be held off, so it
// must be captured when done is high; the back end divides with a 32-stage
// restoring divider, one quotient bit per stage; busy rises only if the queue
// between front and back fills, which a steady one-word-per-cycle stream does
// not cause; the matrix is to be written through cfg_we/cfg_index/cfg_data
// only while no point is in flight, which the block itself does not enforce
module homogeneous_point_projection #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // point channel
    input  logic                               start,
    output logic                               busy,
    input  hpp_pkg::point_t                    point,
    // result channel
    output logic                               done,
    output hpp_pkg::result_t                   result,
    // matrix write port
    input  logic                               cfg_we,
    input  logic [hpp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hpp_pkg::CFG_W-1:0]          cfg_data
);
    import hpp_pkg::*;

    matrix_t matrix_reg;
    logic    take;
    logic    push;
    cols_t   front_cols;
    logic    q_full;
    logic    q_valid;
    cols_t   q_cols;

    // matrix registers, writes past the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg <= CFG_RESET;
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            matrix_reg[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
        end
    end

    assign busy = q_full;
    assign take = start && !busy;

    // front: products and column sums
    hpp_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .point  (point),
        .matrix (matrix_reg),
        .push   (push),
        .cols   (front_cols)
    );

    // queue decouples front and back
    hpp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_cols),
        .full  (q_full),
        .valid (q_valid),
        .pop   (q_valid),
        .dout  (q_cols)
    );

    // back: divide by w and saturate
    hpp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (q_valid),
        .cols   (q_cols),
        .done   (done),
        .result (result)
    );

endmodule

// ===== test/homogeneous_point_projection_test.sv =====
// testbench for the homogeneous point projection block, scoreboard and stimulus
`timescale 1ns / 1ps

module homogeneous_point_projection_test;
    import hpp_pkg::*;

    localparam int FRAC      = 16;
    // extra idle time after the last result word, before the matrix changes
    localparam int SETTLE    = 48;
    // cycles with no point taken, no result and no matrix write before the run is called hung
    localparam int STALL_MAX = 4000;

    // projection predictor plus the store of expected result words
    class projection_board;
        logic signed [31:0] mat [4][4];
        result_t            pending [$];
        int                 errors;

        function new();
            errors = 0;
            pending.delete();
        endfunction

        // one register holds two adjacent columns of one row
        function void load(int idx, logic [63:0] val);
            if (idx < NUM_REGS)
            begin
                mat[idx / 2][(idx % 2) * 2]     = val[31:0];
                mat[idx / 2][(idx % 2) * 2 + 1] = val[63:32];
            end
        endfunction

        function logic [31:0] clamp(logic signed [127:0] s, inout logic ov);
            if (s > 128'sd2147483647)
            begin
                ov = 1'b1;
                return 32'h7fff_ffff;
            end
            if (s < -128'sd2147483648)
            begin
                ov = 1'b1;
                return 32'h8000_0000;
            end
            return s[31:0];
        endfunction

        // expected result word for one accepted point word
        function void note(point_t p);
            logic signed [31:0]  v [3];
            logic signed [127:0] col [4];
            logic signed [127:0] acc;
            logic signed [127:0] w;
            logic        [127:0] num, den, quo, mag;
            logic signed [127:0] sv;
            logic                ov;
            logic        [31:0]  o [3];
            result_t             r;
            v[0] = p.x_in;
            v[1] = p.y_in;
            v[2] = p.z_in;
            // exact sum of products, floored to the point format, plus the row-3 term
            for (int j = 0; j < 4; j++)
            begin
                acc = 0;
                for (int i = 0; i < 3; i++)
                    acc = acc + v[i] * mat[i][j];
                col[j] = (acc >>> FRAC) + mat[3][j];
            end
            w  = col[3];
            ov = 1'b0;
            den = (w < 0) ? -w : w;
            for (int j = 0; j < 3; j++)
            begin
                if (w == 0)
                    o[j] = clamp(col[j], ov);
                else
                begin
                    num = (col[j] < 0) ? -col[j] : col[j];
                    quo = num / den;
                    // a quotient past 32 integer bits saturates either way
                    if ((quo >> 32) != 0)
                        mag = 128'd1 << 33;
                    else
                        mag = (num << FRAC) / den;
                    sv = ((col[j] < 0) != (w < 0)) ? -$signed(mag) : $signed(mag);
                    o[j] = clamp(sv, ov);
                end
            end
            r.x_out      = o[0];
            r.y_out      = o[1];
            r.z_out      = o[2];
            r.w_was_zero = (w == 0);
            r.overflowed = ov;
            pending.insert(pending.size(), r);
        endfunction

        function void check(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.x_out !== want.x_out)
            begin
                $display("%0t: x_out expected %h got %h", $time, want.x_out, got.x_out);
                errors++;
            end
            if (got.y_out !== want.y_out)
            begin
                $display("%0t: y_out expected %h got %h", $time, want.y_out, got.y_out);
                errors++;
            end
            if (got.z_out !== want.z_out)
            begin
                $display("%0t: z_out expected %h got %h", $time, want.z_out, got.z_out);
                errors++;
            end
            if (got.w_was_zero !== want.w_was_zero)
            begin
                $display("%0t: w_was_zero expected %b got %b", $time,
                         want.w_was_zero, got.w_was_zero);
                errors++;
            end
            if (got.overflowed !== want.overflowed)
            begin
                $display("%0t: overflowed expected %b got %b", $time,
                         want.overflowed, got.overflowed);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    point_t               point;
    logic                 done;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    projection_board board;
    int              stall_cycles;
    bit              gaps_on;

    homogeneous_point_projection #(.FRAC_BITS(FRAC)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // monitor: predict on each accepted point word, check each result word
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note(point);
        if (rst_n && done)
            board.check(result);
        if ((start && !busy) || done || cfg_we || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("homogeneous_point_projection_test: errors");
            $finish;
        end
    end

    // coordinate mix: full range, small values, and the corner values
    function automatic logic [31:0] pick_coord();
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return ($urandom_range(0, 1)) ? 32'h0 : 32'hffff_ffff;
            default:
            begin
                mag = $urandom_range(0, 32'h000f_ffff);
                return ($urandom_range(0, 1)) ? -mag : mag;
            end
        endcase
    endfunction

    // matrix entries mostly modest so that the divide does not always saturate
    function automatic logic [31:0] pick_entry();
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'h0;
            2:       return 32'h0001_0000;
            default:
            begin
                mag = $urandom_range(0, 32'h0004_0000);
                return ($urandom_range(0, 1)) ? -mag : mag;
            end
        endcase
    endfunction

    task automatic write_reg(int idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data  <= val;
        board.load(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // hold a point word until the block takes it, then maybe idle a burst
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        start       <= 1'b1;
        point.x_in  <= x;
        point.y_in  <= y;
        point.z_in  <= z;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    // matrix changes only once every point has come back out
    task automatic wait_idle();
        start <= 1'b0;
        @(negedge clk);
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // program all eight registers for one phase, plus a write past the list
    task automatic program_matrix(int kind);
        logic [31:0] e [4][4];
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                case (kind)
                    0:       e[i][j] = 32'h0;
                    1:       e[i][j] = 32'h7fff_ffff;
                    2:       e[i][j] = 32'h8000_0000;
                    // perspective: w taken from z, so w is zero whenever z is
                    3:       e[i][j] = (j == 3) ? ((i == 2) ? 32'h0001_0000 : 32'h0)
                                                : ((i == j) ? 32'h0001_0000 : 32'h0);
                    4:       e[i][j] = (j == 3) ? 32'h0 : pick_entry();
                    default: e[i][j] = pick_entry();
                endcase
        for (int r = 0; r < NUM_REGS; r++)
            write_reg(r, {e[r / 2][(r % 2) * 2 + 1], e[r / 2][(r % 2) * 2]});
        write_reg($urandom_range(NUM_REGS, 15), {$urandom, $urandom});
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        point     = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        gaps_on   = 1'b1;
        stall_cycles = 0;
        board = new();
        for (int r = 0; r < NUM_REGS; r++)
            board.load(r, CFG_RESET[r]);
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed words against the reset matrix: corners and the zero point
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'hffff_ffff, 32'h0000_0001, 32'h0001_0000);
        send_point(32'h0001_8000, 32'hfffe_8000, 32'h8000_0000);
        wait_idle();

        // w is zero for every point: undivided pass-through
        program_matrix(4);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0003_0000);
        send_point(32'h0000_0001, 32'hffff_ffff, 32'h0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        wait_idle();

        // divide by z, including z of zero and a tiny z that saturates
        program_matrix(3);
        send_point(32'h0002_0000, 32'hfffe_0000, 32'h0002_0000);
        send_point(32'h0002_0000, 32'hfffe_0000, 32'h0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        send_point(32'h0005_0000, 32'h0003_0000, 32'hfffe_0000);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        wait_idle();

        // extreme matrices: all zero, all most-positive, all most-negative
        for (int k = 0; k < 3; k++)
        begin
            program_matrix(k);
            send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
            send_point(32'h8000_0000, 32'h0001_0000, 32'hffff_ffff);
            send_point(32'h0, 32'h0, 32'h0);
            wait_idle();
        end

        // random phases over random and special matrices; phases 2 and 6 run back to back
        for (int ph = 0; ph < 7; ph++)
        begin
            program_matrix((ph == 1) ? 3 : (ph == 3) ? 4 : 5);
            gaps_on = (ph != 6) && (ph != 2);
            for (int n = 0; n < 200; n++)
                send_point(pick_coord(), pick_coord(), pick_coord());
            wait_idle();
        end

        if (board.errors == 0)
            $display("homogeneous_point_projection_test: clean");
        else
            $display("homogeneous_point_projection_test: errors");
        $finish;
    end

endmodule
